FILE: rtl/dct_pkg.sv
// package with payload types and codes for the deadline callout timer
package dct_pkg;

  typedef enum logic [2:0] {
    KIND_AT     = 3'd0,
    KIND_AFTER  = 3'd1,
    KIND_EVERY  = 3'd2,
    KIND_CANCEL = 3'd3,
    KIND_QUERY  = 3'd4,
    KIND_EVENT  = 3'd5,
    KIND_READ   = 3'd6,
    KIND_NONE   = 3'd7
  } kind_t;

  localparam logic CFG_MIN = 1'b0;
  localparam logic CFG_MAX = 1'b1;

  localparam int NUM_BOUNDS = 8;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [63:0] now_time;
    logic [63:0] time_value;
    logic [63:0] period_value;
    logic        has_callout;
    logic [3:0]  bucket;
  } req_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_slot;
    logic        called_flag;
    logic        rearmed;
    logic [31:0] next_delay;
    logic [63:0] compare_value;
    logic [31:0] counter_value;
    logic        last;
  } rsp_t;

  // latency bucket upper bounds
  function automatic logic [9:0] bucket_bound(input logic [2:0] idx);
    case (idx)
      3'd0: bucket_bound = 10'd1;
      3'd1: bucket_bound = 10'd2;
      3'd2: bucket_bound = 10'd5;
      3'd3: bucket_bound = 10'd10;
      3'd4: bucket_bound = 10'd20;
      3'd5: bucket_bound = 10'd50;
      3'd6: bucket_bound = 10'd100;
      default: bucket_bound = 10'd1000;
    endcase
  endfunction

endpackage

FILE: rtl/deadline_callout_timer.sv
// deadline-sorted timer slot queue with latency histogram and re-arm logic
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_stall  | req_t
//   out     | output    | out_valid / out_stall| rsp_t
//   cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// a schedule runs accept, an unlink walk and shift when the slot is queued, the slot write,
// an insert walk with one compare per cycle in the shared comparator, and a tail shift.
// a timer event runs accept and the histogram bin search, then per fire a head check,
// a pop shift over the list, the fired result when the slot has a callout and, for a periodic
// slot, a re-insert walk; it ends with one head check, the re-arm step and the final result.
// the block accepts one request at a time; in_stall is high while busy.
// rst clears valid bits, queue length, baseline and histogram, and sets the config registers to defaults.
// each result waits in the output register while out_stall is high; work pauses there.
module deadline_callout_timer
  import dct_pkg::*;
#(
  parameter int SLOTS     = 16,
  parameter int MAX_FIRES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int QW = $clog2(SLOTS + 1);
  localparam int FW = $clog2(MAX_FIRES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_HIST, S_FINDDEL, S_SHIFTDEL, S_PLACE, S_FINDPOS, S_SHIFTINS,
    S_FIRE_HEAD, S_FIRED, S_FIRE_NEXT, S_REARM, S_EMIT, S_WAIT
  } state_t;

  state_t state;
  state_t ret;
  req_t   req;
  logic [31:0] min_interval, max_interval;
  logic [63:0] baseline;
  logic [63:0] deadline_mem [SLOTS];
  logic [63:0] period_mem [SLOTS];
  logic [SLOTS-1:0] valid_bits;
  logic [SLOTS-1:0] report_bits;
  logic [SW-1:0] order [SLOTS];
  logic [QW-1:0] qlen;
  logic [31:0] hist [NUM_BOUNDS+1];

  logic [QW-1:0] idx;
  logic [QW-1:0] sh;
  logic [SW-1:0] cur;          // slot being moved
  logic [63:0]   cur_dl;
  logic [FW-1:0] fires;
  logic [3:0]    hbin;
  logic [15:0]   lat;
  logic          in_event;

  logic [SW-1:0] slot_i;
  logic          slot_ok;
  assign slot_i  = SW'(req.slot);
  assign slot_ok = 32'(req.slot) < SLOTS;

  logic [63:0] head_dl;
  assign head_dl = deadline_mem[order[0]];

  // shared comparator: list entry deadline against target, or head against now
  logic [63:0] cmp_a, cmp_b;
  logic        cmp_le;
  assign cmp_le = cmp_a <= cmp_b;

  always_comb begin
    case (state)
      S_FIRE_HEAD: begin
        cmp_a = head_dl;
        cmp_b = req.now_time;
      end
      default: begin
        cmp_a = deadline_mem[order[idx[SW-1:0]]];
        cmp_b = cur_dl;
      end
    endcase
  end

  // deadline of the slot being scheduled
  logic [63:0] place_dl;
  assign place_dl = (kind_t'(req.kind) == KIND_AT) ? req.time_value
                                                   : req.now_time + req.time_value;

  // re-arm delay selection
  logic [63:0] diff;
  logic [64:0] now_min;
  logic [31:0] delay;
  logic [63:0] next_cmp;
  always_comb begin
    diff    = head_dl - req.now_time;
    now_min = {1'b0, req.now_time} + 65'(min_interval);
    delay   = max_interval;
    if (qlen != '0) begin
      if ({1'b0, head_dl} <= now_min) delay = min_interval;
      else if (diff < 64'(max_interval)) delay = diff[31:0];
    end
  end
  assign next_cmp = req.now_time + 64'(delay);

  // result words
  rsp_t fire_rsp, rearm_rsp, done_rsp;
  always_comb begin
    fire_rsp            = '0;
    fire_rsp.fired      = 1'b1;
    fire_rsp.fired_slot = 4'(cur);
    rearm_rsp               = '0;
    rearm_rsp.rearmed       = 1'b1;
    rearm_rsp.next_delay    = delay;
    rearm_rsp.compare_value = next_cmp;
    rearm_rsp.last          = 1'b1;
    done_rsp      = '0;
    done_rsp.last = 1'b1;
    case (kind_t'(req.kind))
      KIND_QUERY: done_rsp.called_flag = !(slot_ok && valid_bits[slot_i]);
      KIND_READ:  done_rsp.counter_value = (req.bucket <= 4'(NUM_BOUNDS)) ? hist[req.bucket]
                                                                          : 32'd0;
      default: ;
    endcase
  end

  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);

  // sequencer and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      valid_bits   <= '0;
      qlen         <= '0;
      baseline     <= '0;
      min_interval <= 32'd50;
      max_interval <= 32'd50000000;
      for (int i = 0; i <= NUM_BOUNDS; i++) hist[i] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_MIN) min_interval <= cfg_data;
        else max_interval <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            req      <= in_data;
            idx      <= '0;
            fires    <= '0;
            hbin     <= '0;
            cur      <= SW'(in_data.slot);
            lat      <= in_data.now_time[15:0] - baseline[15:0];
            in_event <= (kind_t'(in_data.kind) == KIND_EVENT);
            case (kind_t'(in_data.kind))
              KIND_EVENT: state <= S_HIST;
              KIND_AT, KIND_AFTER, KIND_EVERY, KIND_CANCEL: begin
                if (32'(in_data.slot) >= SLOTS) state <= S_EMIT;
                else if (valid_bits[SW'(in_data.slot)]) state <= S_FINDDEL;
                else state <= S_PLACE;
              end
              default: state <= S_EMIT;
            endcase
          end
        end
        // one bucket bound per cycle
        S_HIST: begin
          if (hbin == 4'(NUM_BOUNDS) ||
              {6'd0, bucket_bound(hbin[2:0])} >= lat) begin
            hist[hbin] <= hist[hbin] + 32'd1;
            state      <= S_FIRE_HEAD;
          end else begin
            hbin <= hbin + 4'd1;
          end
        end
        // find the queued slot to unlink
        S_FINDDEL: begin
          if (order[idx[SW-1:0]] == cur) state <= S_SHIFTDEL;
          else idx <= idx + 1'b1;
        end
        // close the gap one entry per cycle
        S_SHIFTDEL: begin
          if (idx + 1'b1 >= qlen) begin
            qlen            <= qlen - 1'b1;
            valid_bits[cur] <= 1'b0;
            if (in_event) begin
              fires <= fires + 1'b1;
              state <= S_FIRED;
            end else begin
              state <= S_PLACE;
            end
          end else begin
            order[idx[SW-1:0]] <= order[SW'(idx + 1'b1)];
            idx <= idx + 1'b1;
          end
        end
        // write slot fields, then start insert walk; a cancel only clears the period
        S_PLACE: begin
          idx <= '0;
          if (kind_t'(req.kind) == KIND_CANCEL) begin
            period_mem[cur] <= '0;
            state <= S_EMIT;
          end else begin
            cur_dl            <= place_dl;
            deadline_mem[cur] <= place_dl;
            period_mem[cur]   <= (kind_t'(req.kind) == KIND_EVERY) ? req.period_value
                                                                   : 64'd0;
            report_bits[cur]  <= req.has_callout;
            state <= S_FINDPOS;
          end
        end
        // walk past entries with deadline not above ours
        S_FINDPOS: begin
          if (qlen >= QW'(SLOTS)) begin
            state <= in_event ? S_FIRE_HEAD : S_EMIT;
          end else if (idx < qlen && cmp_le) begin
            idx <= idx + 1'b1;
          end else begin
            sh    <= qlen;
            state <= S_SHIFTINS;
          end
        end
        // open a hole from the tail down to idx, then link
        S_SHIFTINS: begin
          if (sh == idx) begin
            order[idx[SW-1:0]] <= cur;
            qlen            <= qlen + 1'b1;
            valid_bits[cur] <= 1'b1;
            if (in_event) state <= S_FIRE_HEAD;
            else if (idx == '0) state <= S_REARM;
            else state <= S_EMIT;
          end else begin
            order[sh[SW-1:0]] <= order[SW'(sh - 1'b1)];
            sh <= sh - 1'b1;
          end
        end
        // pop the head while due and under the fire cap
        S_FIRE_HEAD: begin
          if (qlen != '0 && fires < FW'(MAX_FIRES) && cmp_le) begin
            cur    <= order[0];
            cur_dl <= head_dl;
            idx    <= '0;
            state  <= S_SHIFTDEL;
          end else begin
            state <= S_REARM;
          end
        end
        // report the firing when the slot has a callout
        S_FIRED: begin
          if (report_bits[cur]) begin
            out_data  <= fire_rsp;
            out_valid <= 1'b1;
            ret       <= S_FIRE_NEXT;
            state     <= S_WAIT;
          end else begin
            state <= S_FIRE_NEXT;
          end
        end
        // periodic slots go back in at old deadline plus period
        S_FIRE_NEXT: begin
          if (period_mem[cur] != '0) begin
            cur_dl            <= cur_dl + period_mem[cur];
            deadline_mem[cur] <= cur_dl + period_mem[cur];
            idx               <= '0;
            state             <= S_FINDPOS;
          end else begin
            state <= S_FIRE_HEAD;
          end
        end
        S_REARM: begin
          out_data  <= rearm_rsp;
          baseline  <= next_cmp;
          out_valid <= 1'b1;
          ret       <= S_IDLE;
          state     <= S_WAIT;
        end
        S_EMIT: begin
          out_data  <= done_rsp;
          out_valid <= 1'b1;
          ret       <= S_IDLE;
          state     <= S_WAIT;
        end
        // hold the result until taken
        S_WAIT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= ret;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // handshake and queue checks
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data));
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall);
  a_qlen_range: assert property (@(posedge clk) disable iff (rst)
    qlen <= QW'(SLOTS));
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !out_valid);

endmodule

FILE: dv/tb_deadline_callout_timer.sv
// self-checking testbench for the deadline callout timer: directed and random requests
module tb_deadline_callout_timer;
  import dct_pkg::*;

  localparam int NSLOT     = 16;
  localparam int FIRE_CAP  = 16;
  localparam int LIMIT     = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rsp_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_MIN;
  logic [31:0] cfg_data = '0;

  deadline_callout_timer u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // timer model state
  logic [31:0] min_gap, max_gap;
  logic [63:0] dl_q [NSLOT];
  logic [63:0] per_q [NSLOT];
  logic        armed_q [NSLOT];
  logic        notify_q [NSLOT];
  logic [3:0]  order_q [NSLOT];
  int          qlen;
  logic [63:0] baseline;
  logic [31:0] hist [9];
  logic [63:0] bounds [8] = '{1, 2, 5, 10, 20, 50, 100, 1000};

  rsp_t expected_rsp [$];
  int   mismatches = 0;
  bit   failed = 0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  logic [63:0] clock_us = 64'd1000;

  // remove a slot from the deadline order
  function automatic void drop_slot(input logic [3:0] s);
    int i;
    int j;
    if (!armed_q[s]) return;
    for (i = 0; i < qlen; i++) begin
      if (order_q[i] == s) begin
        for (j = i; j + 1 < qlen; j++) order_q[j] = order_q[j + 1];
        qlen--;
        break;
      end
    end
    armed_q[s] = 1'b0;
  endfunction

  // insert behind equal deadlines, returns 1 when at head
  function automatic bit insert_slot(input logic [3:0] s);
    int p;
    int j;
    p = 0;
    if (qlen >= NSLOT) return 1'b0;
    while (p < qlen && dl_q[order_q[p]] <= dl_q[s]) p++;
    for (j = qlen; j > p; j--) order_q[j] = order_q[j - 1];
    order_q[p] = s;
    qlen++;
    armed_q[s] = 1'b1;
    return p == 0;
  endfunction

  // recompute compare value
  function automatic void rearm_into(input logic [63:0] now, inout rsp_t r);
    logic [63:0] delay;
    logic [63:0] d;
    delay = {32'd0, max_gap};
    if (qlen > 0) begin
      d = dl_q[order_q[0]];
      if (d <= now || d - now <= {32'd0, min_gap}) delay = {32'd0, min_gap};
      else if (d - now < {32'd0, max_gap}) delay = d - now;
    end
    baseline = now + delay;
    r.rearmed = 1'b1;
    r.next_delay = delay[31:0];
    r.compare_value = baseline;
  endfunction

  // predict the responses of one accepted request
  function automatic void predict_timer(input req_t q);
    rsp_t r;
    logic [15:0] lat;
    logic [63:0] dl;
    logic [3:0] h;
    int i;
    int fires;
    if (q.kind == KIND_EVENT) begin
      lat = q.now_time[15:0] - baseline[15:0];
      i = 0;
      while (i < 8 && {48'd0, lat} > bounds[i]) i++;
      hist[i]++;
      fires = 0;
      while (qlen > 0 && fires < FIRE_CAP) begin
        h = order_q[0];
        dl = dl_q[h];
        if (dl > q.now_time) break;
        drop_slot(h);
        fires++;
        if (notify_q[h]) begin
          r = '0;
          r.fired = 1'b1;
          r.fired_slot = h;
          expected_rsp.push_back(r);
        end
        if (per_q[h] != 0) begin
          dl_q[h] = dl + per_q[h];
          void'(insert_slot(h));
        end
      end
      r = '0;
      rearm_into(q.now_time, r);
      r.last = 1'b1;
      expected_rsp.push_back(r);
      return;
    end
    r = '0;
    r.last = 1'b1;
    case (q.kind)
      KIND_AT, KIND_AFTER, KIND_EVERY: begin
        drop_slot(q.slot);
        dl_q[q.slot] = (q.kind == KIND_AT) ? q.time_value : q.now_time + q.time_value;
        per_q[q.slot] = (q.kind == KIND_EVERY) ? q.period_value : 64'd0;
        notify_q[q.slot] = q.has_callout;
        if (insert_slot(q.slot)) rearm_into(q.now_time, r);
      end
      KIND_CANCEL: begin
        drop_slot(q.slot);
        per_q[q.slot] = 64'd0;
      end
      KIND_QUERY: r.called_flag = !armed_q[q.slot];
      KIND_READ: r.counter_value = (q.bucket <= 8) ? hist[q.bucket] : 32'd0;
      default: ;
    endcase
    expected_rsp.push_back(r);
  endfunction

  // drive one request and predict it when accepted
  task automatic send_request(input req_t q);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_data <= q;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_timer(q);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait_drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_MIN) min_gap = val;
    else max_gap = val;
  endtask

  function automatic req_t make_req(input kind_t k, input logic [3:0] s,
                                    input logic [63:0] tv, input logic [63:0] pv,
                                    input logic cb);
    req_t q;
    q = '0;
    q.kind = k;
    q.slot = s;
    q.now_time = clock_us;
    q.time_value = tv;
    q.period_value = pv;
    q.has_callout = cb;
    q.bucket = 4'($urandom_range(15));
    return q;
  endfunction

  // receiver stall and response checking
  always @(posedge clk) begin
    rsp_t e;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsp.size() == 0) begin
          failed = 1;
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", out_data);
        end else begin
          e = expected_rsp.pop_front();
          if (out_data !== e) begin
            failed = 1;
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, out_data);
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // run limit
  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic test_directed();
    req_t q;
    int b;
    q = make_req(KIND_QUERY, 4'd0, 64'd0, 64'd0, 1'b0);
    send_request(q);
    send_request(make_req(KIND_AT, 4'd0, clock_us + 10, 64'd0, 1'b1));
    send_request(make_req(KIND_AT, 4'd1, clock_us + 10, 64'd0, 1'b1));
    send_request(make_req(KIND_AFTER, 4'd15, 64'd5, 64'd0, 1'b0));
    send_request(make_req(KIND_EVERY, 4'd7, 64'd3, 64'd4, 1'b1));
    send_request(make_req(KIND_AT, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 1'b1));
    send_request(make_req(KIND_EVERY, 4'd9, 64'hFFFF_FFFF_FFFF_FFFF,
                          64'hFFFF_FFFF_FFFF_FFFF, 1'b1));
    send_request(make_req(KIND_QUERY, 4'd7, 64'd0, 64'd0, 1'b0));
    send_request(make_req(KIND_CANCEL, 4'd15, 64'd0, 64'd0, 1'b0));
    send_request(make_req(KIND_CANCEL, 4'd3, 64'd0, 64'd0, 1'b0));
    send_request(make_req(KIND_NONE, 4'd2, 64'd0, 64'd0, 1'b0));
    clock_us = clock_us + 20;
    send_request(make_req(KIND_EVENT, 4'd0, 64'd0, 64'd0, 1'b0));
    // periodic slots stay due for more firings than one event may make
    for (int s = 0; s < NSLOT; s++)
      send_request(make_req(KIND_EVERY, s[3:0], 64'd0, 64'd1, s[0]));
    clock_us = clock_us + 100;
    send_request(make_req(KIND_EVENT, 4'd0, 64'd0, 64'd0, 1'b0));
    send_request(make_req(KIND_EVENT, 4'd0, 64'd0, 64'd0, 1'b0));
    for (b = 0; b < 16; b++) begin
      q = make_req(KIND_READ, 4'd0, 64'd0, 64'd0, 1'b0);
      q.bucket = b[3:0];
      send_request(q);
    end
    for (int s = 0; s < NSLOT; s++)
      send_request(make_req(KIND_CANCEL, s[3:0], 64'd0, 64'd0, 1'b0));
  endtask

  // random requests with mostly nearby deadlines
  task automatic test_random(input int count);
    req_t q;
    int k;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      clock_us = clock_us + $urandom_range(60);
      if ($urandom_range(30) == 0) clock_us = {$urandom, $urandom};
      if (k < 45)
        q = make_req(kind_t'($urandom_range(2)), 4'($urandom_range(15)),
                     ($urandom_range(3) == 0) ? {$urandom, $urandom} : $urandom_range(200),
                     ($urandom_range(3) == 0) ? {$urandom, $urandom} : $urandom_range(80),
                     1'($urandom_range(1)));
      else if (k < 52)
        q = make_req(KIND_CANCEL, 4'($urandom_range(15)), 64'd0, 64'd0, 1'b0);
      else if (k < 60)
        q = make_req(KIND_QUERY, 4'($urandom_range(15)), 64'd0, 64'd0, 1'b0);
      else if (k < 90) q = make_req(KIND_EVENT, 4'd0, 64'd0, 64'd0, 1'b0);
      else if (k < 97) q = make_req(KIND_READ, 4'd0, 64'd0, 64'd0, 1'b0);
      else q = make_req(KIND_NONE, 4'($urandom_range(15)), 64'd0, 64'd0, 1'b0);
      if (k < 45 && q.kind == KIND_AT) q.time_value = clock_us + q.time_value;
      if ($urandom_range(9) == 0) begin
        q.now_time = {$urandom, $urandom};
        q.time_value = {$urandom, $urandom};
        q.period_value = {$urandom, $urandom};
      end
      send_request(q);
    end
  endtask

  task automatic test_config_sweep();
    write_reg(CFG_MIN, 32'd1);
    write_reg(CFG_MAX, 32'd1);
    test_random(4);
    write_reg(CFG_MIN, 32'hFFFF_FFFF);
    write_reg(CFG_MAX, 32'hFFFF_FFFF);
    test_random(4);
    write_reg(CFG_MIN, 32'd7);
    write_reg(CFG_MAX, 32'd90);
    test_random(4);
  endtask

  initial begin
    min_gap = 32'd50;
    max_gap = 32'd50000000;
    qlen = 0;
    baseline = '0;
    for (int i = 0; i < NSLOT; i++) begin
      armed_q[i] = 1'b0;
      per_q[i] = '0;
      dl_q[i] = '0;
      notify_q[i] = 1'b0;
      order_q[i] = '0;
    end
    for (int i = 0; i < 9; i++) hist[i] = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(10);
    send_idle_pct = 73;
    test_random(8);
    send_idle_pct = 0;
    stall_pct = 73;
    test_random(8);
    send_idle_pct = 10;
    stall_pct = 10;
    test_random(8);
    send_idle_pct = 0;
    stall_pct = 0;
    test_config_sweep();
    wait_drain();
    if (!failed && expected_rsp.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: deadline_callout_timer.f
rtl/dct_pkg.sv
rtl/deadline_callout_timer.sv
dv/tb_deadline_callout_timer.sv
